### rtl/fwcb_pkg.sv
`default_nettype none
package fwcb_pkg;

    // Breaker states as reported in state_after
    typedef enum logic [1:0] {
        BRK_CLOSED = 2'd0,
        BRK_OPEN   = 2'd1,
        BRK_HALF   = 2'd2
    } brk_state_t;

    // Request kinds carried on s_tuser
    localparam logic [1:0] MODE_CALL  = 2'd0;
    localparam logic [1:0] MODE_PROBE = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_FAIL_THR   = 3'd0;
    localparam logic [2:0] REG_SUCC_THR   = 3'd1;
    localparam logic [2:0] REG_OPEN_TMO   = 3'd2;
    localparam logic [2:0] REG_HALF_MAX   = 3'd3;
    localparam logic [2:0] REG_WIN_USED   = 3'd4;
    localparam logic [2:0] REG_WIN_TIME   = 3'd5;

    // Register reset values
    localparam logic [15:0] FAIL_THR_RST = 16'd5;
    localparam logic [15:0] SUCC_THR_RST = 16'd2;
    localparam logic [30:0] OPEN_TMO_RST = 31'd30000;
    localparam logic [15:0] HALF_MAX_RST = 16'd1;
    localparam logic [7:0]  WIN_USED_RST = 8'd100;
    localparam logic [30:0] WIN_TIME_RST = 31'd60000;

    // Window entry: {failed, time}
    localparam int ENTRY_W = 33;

    // One result, packed from the highest bit down as on m_tdata
    typedef struct packed {
        logic [7:0] wcount;
        logic       changed;
        logic [1:0] state;
        logic       timed;
        logic       failed;
        logic       admitted;
    } res_t;

endpackage
`default_nettype wire

### rtl/fwcb_ram.sv
`default_nettype none
module fwcb_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/failure_window_circuit_breaker.sv
`default_nettype none
// Three-state circuit breaker (closed, open, half-open) with a ring window.
// Input stream s_*: one request per call, forced probe, reset or query; the
//   kind is on s_tuser, time and call outcome on s_tdata.
// Output stream m_*: exactly one result per request, in order.
// Configuration: APB port, six registers at byte addresses 0x00..0x14. The user
//   must write them only while no request is in flight; the block does not enforce it.
// Most requests pass through the evaluate and output states only. A
//   failing call in the closed state scans the window through the single
//   read port of the entry RAM, one read per entry in use (at most
//   WINDOW_DEPTH, 100 at reset).
// Requests: a new one is taken only after the last has left the sequencer;
//   s_tready is high only while the sequencer is idle.
// Stalls: the result sits in an output register; the next request is taken
//   while it waits, and is held back at completion until m_tready frees it.
// Reset: breaker closed, streaks and window cleared, registers to defaults.
//   The entry RAM needs no clearing pass; only written entries are read.
module failure_window_circuit_breaker
    import fwcb_pkg::*;
#(
    parameter int WINDOW_DEPTH = 128,
    parameter int STREAK_WIDTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata: now_ms[31:0], call_error[32], call_duration_ms[64:33],
    //          call_timeout_ms[96:65], zero fill [103:97]
    input  wire logic [103:0] s_tdata,
    // s_tuser: mode[1:0]
    input  wire logic [1:0]   s_tuser,
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata: admitted[0], call_failed[1], call_timed_out[2], state_after[4:3],
    //          state_changed[5], window_failure_count[13:6], zero fill [15:14]
    output logic [15:0]       m_tdata,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = STREAK_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FINAL,
        S_OUT
    } fsm_t;

    // configuration registers
    logic [15:0] fail_thr_reg, succ_thr_reg, half_max_reg;
    logic [30:0] open_tmo_reg, win_time_reg;
    logic [7:0]  win_used_reg;

    // control and breaker state
    fsm_t          fsm_reg, fsm_next;
    brk_state_t    brk_reg, brk_next;
    logic [SW-1:0] fstreak_reg, fstreak_next;
    logic [SW-1:0] sstreak_reg, sstreak_next;
    logic [31:0]   last_reg, last_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          full_reg, full_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rdv_reg, rdv_next;
    res_t          res_reg, res_next;
    logic          mv_reg, mv_next;
    res_t          mout_reg, mout_next;

    // latched request
    logic [1:0]  mode_reg;
    logic [31:0] now_reg, dur_reg, tmo_reg;
    logic        err_reg;

    // entry RAM ports
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic          cfg_wr;
    logic [CW-1:0] used;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign s_tready = (fsm_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, mout_reg};

    // register read-back
    always_comb
    begin
        unique case (paddr[4:2])
            REG_FAIL_THR: prdata = {16'd0, fail_thr_reg};
            REG_SUCC_THR: prdata = {16'd0, succ_thr_reg};
            REG_OPEN_TMO: prdata = {1'b0, open_tmo_reg};
            REG_HALF_MAX: prdata = {16'd0, half_max_reg};
            REG_WIN_USED: prdata = {24'd0, win_used_reg};
            REG_WIN_TIME: prdata = {1'b0, win_time_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // window entries in use, clamped to 1..WINDOW_DEPTH
    always_comb
    begin
        if (win_used_reg == 8'd0)
        begin
            used = CW'(1);
        end
        else if (32'(win_used_reg) > 32'(WINDOW_DEPTH))
        begin
            used = CW'(WINDOW_DEPTH);
        end
        else
        begin
            used = CW'(win_used_reg);
        end
    end

    // sequencer: evaluate, optional window scan, result hand-off
    always_comb
    begin
        brk_state_t    st;
        logic [SW-1:0] f, s;
        logic          chg, fast, timed, failed, expired;
        logic [CW-1:0] pos_inc;

        fsm_next     = fsm_reg;
        brk_next     = brk_reg;
        fstreak_next = fstreak_reg;
        sstreak_next = sstreak_reg;
        last_next    = last_reg;
        wp_next      = wp_reg;
        full_next    = full_reg;
        issue_next   = issue_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        rdv_next     = 1'b0;
        res_next     = res_reg;
        mv_next      = mv_reg;
        mout_next    = mout_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = issue_reg[AW-1:0];
        ram_wdata    = {1'b0, now_reg};

        st      = brk_reg;
        f       = fstreak_reg;
        s       = sstreak_reg;
        chg     = 1'b0;
        fast    = 1'b0;
        timed   = (tmo_reg != 32'd0) && (dur_reg > tmo_reg);
        failed  = err_reg || timed;
        expired = (now_reg - last_reg) >= {1'b0, open_tmo_reg};
        pos_inc = CW'(wp_reg) + CW'(1);

        // a result leaves when the receiver takes it
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    fsm_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                res_next = '0;
                fsm_next = S_OUT;
                unique case (mode_reg)
                    MODE_RESET:
                    begin
                        fstreak_next = '0;
                        sstreak_next = '0;
                        wp_next      = '0;
                        full_next    = 1'b0;
                        if (brk_reg != BRK_CLOSED)
                        begin
                            brk_next  = BRK_CLOSED;
                            last_next = now_reg;
                            chg       = 1'b1;
                        end
                        res_next.state   = BRK_CLOSED;
                        res_next.changed = chg;
                    end

                    MODE_QUERY:
                    begin
                        res_next.state = (brk_reg == BRK_OPEN && expired) ? BRK_HALF : brk_reg;
                    end

                    default:
                    begin
                        // forced probe or expired timeout leaves open
                        if (st == BRK_OPEN)
                        begin
                            if (mode_reg == MODE_PROBE || expired)
                            begin
                                st  = BRK_HALF;
                                f   = '0;
                                s   = '0;
                                chg = 1'b1;
                                last_next = now_reg;
                            end
                            else
                            begin
                                fast = 1'b1;
                            end
                        end
                        if (!fast && st == BRK_HALF &&
                            (33'(s) + 33'(f) >= 33'(half_max_reg)))
                        begin
                            fast = 1'b1;
                        end
                        if (!fast)
                        begin
                            res_next.admitted = 1'b1;
                            res_next.failed   = failed;
                            res_next.timed    = timed;
                            // record the outcome in the ring
                            ram_we    = 1'b1;
                            ram_wdata = {failed, now_reg};
                            if (pos_inc >= used)
                            begin
                                wp_next   = '0;
                                full_next = 1'b1;
                                n_next    = used;
                            end
                            else
                            begin
                                wp_next = pos_inc[AW-1:0];
                                n_next  = full_reg ? used : pos_inc;
                            end
                            if (failed)
                            begin
                                if (f != '1)
                                begin
                                    f = f + SW'(1);
                                end
                                s = '0;
                                if (st == BRK_HALF)
                                begin
                                    st  = BRK_OPEN;
                                    f   = '0;
                                    chg = 1'b1;
                                    last_next = now_reg;
                                end
                                else if (st == BRK_CLOSED)
                                begin
                                    fsm_next   = S_SCAN;
                                    issue_next = '0;
                                    cnt_next   = '0;
                                end
                            end
                            else
                            begin
                                if (s != '1)
                                begin
                                    s = s + SW'(1);
                                end
                                f = '0;
                                if (st == BRK_HALF && 33'(s) >= 33'(succ_thr_reg))
                                begin
                                    st  = BRK_CLOSED;
                                    s   = '0;
                                    chg = 1'b1;
                                    last_next = now_reg;
                                end
                            end
                        end
                        brk_next         = st;
                        fstreak_next     = f;
                        sstreak_next     = s;
                        res_next.state   = st;
                        res_next.changed = chg;
                    end
                endcase
            end

            S_SCAN:
            begin
                // one read issued per cycle, its data counted in the next cycle
                if (issue_reg < n_reg)
                begin
                    ram_re     = 1'b1;
                    issue_next = issue_reg + CW'(1);
                    rdv_next   = 1'b1;
                end
                if (rdv_reg && ram_rdata[32] &&
                    ((now_reg - ram_rdata[31:0]) <= {1'b0, win_time_reg}))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (issue_reg == n_reg && !rdv_reg)
                begin
                    fsm_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                res_next.wcount = 8'(cnt_reg);
                if (32'(cnt_reg) >= 32'(fail_thr_reg))
                begin
                    brk_next         = BRK_OPEN;
                    last_next        = now_reg;
                    fstreak_next     = '0;
                    sstreak_next     = '0;
                    res_next.state   = BRK_OPEN;
                    res_next.changed = 1'b1;
                end
                fsm_next = S_OUT;
            end

            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next   = 1'b1;
                    mout_next = res_reg;
                    fsm_next  = S_IDLE;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= S_IDLE;
            brk_reg      <= BRK_CLOSED;
            fstreak_reg  <= '0;
            sstreak_reg  <= '0;
            last_reg     <= '0;
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            issue_reg    <= '0;
            n_reg        <= '0;
            cnt_reg      <= '0;
            rdv_reg      <= 1'b0;
            res_reg      <= '0;
            mv_reg       <= 1'b0;
            mout_reg     <= '0;
            mode_reg     <= MODE_CALL;
            now_reg      <= '0;
            err_reg      <= 1'b0;
            dur_reg      <= '0;
            tmo_reg      <= '0;
            fail_thr_reg <= FAIL_THR_RST;
            succ_thr_reg <= SUCC_THR_RST;
            open_tmo_reg <= OPEN_TMO_RST;
            half_max_reg <= HALF_MAX_RST;
            win_used_reg <= WIN_USED_RST;
            win_time_reg <= WIN_TIME_RST;
        end
        else
        begin
            fsm_reg     <= fsm_next;
            brk_reg     <= brk_next;
            fstreak_reg <= fstreak_next;
            sstreak_reg <= sstreak_next;
            last_reg    <= last_next;
            wp_reg      <= wp_next;
            full_reg    <= full_next;
            issue_reg   <= issue_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            rdv_reg     <= rdv_next;
            res_reg     <= res_next;
            mv_reg      <= mv_next;
            mout_reg    <= mout_next;
            if (s_tvalid && s_tready)
            begin
                mode_reg <= s_tuser;
                now_reg  <= s_tdata[31:0];
                err_reg  <= s_tdata[32];
                dur_reg  <= s_tdata[64:33];
                tmo_reg  <= s_tdata[96:65];
            end
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_FAIL_THR: fail_thr_reg <= pwdata[15:0];
                    REG_SUCC_THR: succ_thr_reg <= pwdata[15:0];
                    REG_OPEN_TMO: open_tmo_reg <= pwdata[30:0];
                    REG_HALF_MAX: half_max_reg <= pwdata[15:0];
                    REG_WIN_USED: win_used_reg <= pwdata[7:0];
                    REG_WIN_TIME: win_time_reg <= pwdata[30:0];
                    default:      ;
                endcase
            end
        end
    end

    fwcb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // an accepted request is always evaluated next
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (fsm_reg == S_EVAL))
        else $error("accepted request not evaluated");

    // the scan never issues past the entries in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_SCAN) |-> (issue_reg <= n_reg))
        else $error("window scan overran");

    // a fast fail carries no call outcome
    a_fast_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !mout_reg.admitted) |-> (!mout_reg.failed && !mout_reg.timed))
        else $error("outcome on a call that did not run");

    // a window count only comes with a failed call
    a_count_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && mout_reg.wcount != 8'd0) |-> mout_reg.failed)
        else $error("window count without failure");

    // a timeout is always counted as a failure
    a_timed_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && mout_reg.timed) |-> mout_reg.failed)
        else $error("timeout not counted as failure");

endmodule
`default_nettype wire
